FILE: sv/mapg_pkg.sv
// Shared types and constants for the memory access pattern generator.
package mapg_pkg;

    localparam int unsigned ADDR_W      = 30;
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned LEN_W       = 31;
    localparam int unsigned CNT_W       = 31;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned BYTE_W      = 8;

    localparam int unsigned SEED_WORDS  = 4;
    localparam int unsigned SEED_IDX_W  = $clog2(SEED_WORDS);
    localparam int unsigned REM_STEPS   = WORD_W;
    localparam int unsigned STEP_W      = $clog2(REM_STEPS);

    localparam logic [BYTE_W-1:0] WRITE_BYTE    = 8'h12;
    localparam logic [WORD_W-1:0] SPARSE_OFFSET = 32'd65;
    localparam logic [WORD_W-1:0] SEED_MULT     = 32'd1812433253;
    localparam int unsigned       SEED_SHIFT    = 30;
    localparam int unsigned       XS_SHIFT_A    = 11;
    localparam int unsigned       XS_SHIFT_B    = 19;
    localparam int unsigned       XS_SHIFT_C    = 8;

    localparam logic [LEN_W-1:0]  LEN_RESET     = 31'd1073741824;
    localparam logic [CNT_W-1:0]  COUNT_RESET   = 31'd1;
    localparam logic [MODE_W-1:0] MODE_RESET    = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_LENGTH = 2'd1,
        REG_COUNT  = 2'd2,
        REG_SEED   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PAT_SEQ    = 2'd0,
        PAT_SPARSE = 2'd1,
        PAT_RANDOM = 2'd2,
        PAT_SPARE  = 2'd3
    } pattern_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SEED,
        ST_GEN,
        ST_REM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                  seed_step;
        logic                  seed_zero;
        logic [SEED_IDX_W-1:0] seed_idx;
        logic                  gen;
        logic                  rem_step;
        logic                  out_load;
    } dp_cmd_t;

endpackage

FILE: sv/memory_access_pattern_generator_core.sv
// Top level of the memory access pattern generator: configuration registers and core wiring.
//
//   Channel   Signals                                    Direction
//   in        in_valid, in_ready, restart                request in
//   out       out_valid, out_ready, address, is_write,   request out
//             write_byte, last
//   cfg       cfg_wr_en, cfg_index, cfg_data             register write
//
// An accepted request passes through the generate state, the 32-step radix-2 remainder
// by the region length and the done state before its result is registered; with restart
// the seed state comes first. A new request is taken only after the previous one leaves the
// done state. After reset the four generator words are seeded from zero before the first
// request is taken. A result waits in the output register while the next request is
// taken; a stalled output holds the finished request in its last state.
module memory_access_pattern_generator_core
#(
    parameter int unsigned ADDR_BITS = 30
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  restart,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [mapg_pkg::ADDR_W-1:0]           address,
    output logic                                  is_write,
    output logic [mapg_pkg::BYTE_W-1:0]           write_byte,
    output logic                                  last,
    input  logic                                  cfg_wr_en,
    input  logic [mapg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mapg_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [mapg_pkg::MODE_W-1:0] mode_reg;
    logic [mapg_pkg::LEN_W-1:0]  length_reg;
    logic [mapg_pkg::CNT_W-1:0]  count_reg;
    logic [mapg_pkg::WORD_W-1:0] seed_reg;
    mapg_pkg::dp_cmd_t           cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= mapg_pkg::MODE_RESET;
            length_reg <= mapg_pkg::LEN_RESET;
            count_reg  <= mapg_pkg::COUNT_RESET;
            seed_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (mapg_pkg::cfg_reg_t'(cfg_index))
                mapg_pkg::REG_MODE:   mode_reg   <= cfg_data[mapg_pkg::MODE_W-1:0];
                mapg_pkg::REG_LENGTH: length_reg <= cfg_data[mapg_pkg::LEN_W-1:0];
                mapg_pkg::REG_COUNT:  count_reg  <= cfg_data[mapg_pkg::CNT_W-1:0];
                mapg_pkg::REG_SEED:   seed_reg   <= cfg_data;
                default:              seed_reg   <= seed_reg;
            endcase
        end
    end

    mapg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    mapg_datapath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath
    (
        .clk           (clk),
        .cmd           (cmd),
        .access_mode   (mode_reg),
        .region_length (length_reg),
        .access_count  (count_reg),
        .seed_value    (seed_reg),
        .address       (address),
        .is_write      (is_write),
        .write_byte    (write_byte),
        .last          (last)
    );

endmodule

FILE: sv/mapg_ctrl.sv
// Controller state machine that sequences seeding, generation, remainder and output.
module mapg_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_ready,
    output mapg_pkg::dp_cmd_t  cmd
);

    localparam int unsigned SW = mapg_pkg::STEP_W;

    mapg_pkg::state_t state_reg;
    mapg_pkg::state_t state_next;
    logic [SW-1:0]    step_reg;
    logic [SW-1:0]    step_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mapg_pkg::ST_INIT;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.seed_idx = step_reg[mapg_pkg::SEED_IDX_W-1:0];
        unique case (state_reg)
            mapg_pkg::ST_INIT:
            begin
                cmd.seed_step = 1'b1;
                cmd.seed_zero = 1'b1;
                if (step_reg == SW'(mapg_pkg::SEED_WORDS - 1))
                begin
                    state_next = mapg_pkg::ST_IDLE;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + SW'(1);
                end
            end
            mapg_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                step_next = '0;
                if (in_valid)
                begin
                    state_next = restart ? mapg_pkg::ST_SEED : mapg_pkg::ST_GEN;
                end
            end
            mapg_pkg::ST_SEED:
            begin
                cmd.seed_step = 1'b1;
                if (step_reg == SW'(mapg_pkg::SEED_WORDS - 1))
                begin
                    state_next = mapg_pkg::ST_GEN;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + SW'(1);
                end
            end
            mapg_pkg::ST_GEN:
            begin
                cmd.gen    = 1'b1;
                state_next = mapg_pkg::ST_REM;
                step_next  = '0;
            end
            mapg_pkg::ST_REM:
            begin
                cmd.rem_step = 1'b1;
                if (step_reg == SW'(mapg_pkg::REM_STEPS - 1))
                begin
                    state_next = mapg_pkg::ST_DONE;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + SW'(1);
                end
            end
            mapg_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mapg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mapg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/mapg_datapath.sv
// Datapath with generator words, run index, radix-2 remainder unit and output register.
module mapg_datapath
#(
    parameter int unsigned ADDR_BITS = 30
)
(
    input  logic                              clk,
    input  mapg_pkg::dp_cmd_t                 cmd,
    input  logic [mapg_pkg::MODE_W-1:0]       access_mode,
    input  logic [mapg_pkg::LEN_W-1:0]        region_length,
    input  logic [mapg_pkg::CNT_W-1:0]        access_count,
    input  logic [mapg_pkg::WORD_W-1:0]       seed_value,
    output logic [mapg_pkg::ADDR_W-1:0]       address,
    output logic                              is_write,
    output logic [mapg_pkg::BYTE_W-1:0]       write_byte,
    output logic                              last
);

    localparam int unsigned AW = mapg_pkg::ADDR_W;
    localparam int unsigned WW = mapg_pkg::WORD_W;
    localparam int unsigned LW = mapg_pkg::LEN_W;
    localparam int unsigned CW = mapg_pkg::CNT_W;
    localparam logic [AW-1:0] ADDR_MASK = (ADDR_BITS >= AW) ? {AW{1'b1}}
                                        : AW'((64'd1 << ADDR_BITS) - 64'd1);

    logic [WW-1:0]          rng_reg [mapg_pkg::SEED_WORDS];
    logic [WW-1:0]          seed_reg;
    logic [CW-1:0]          idx_reg;
    logic [CW-1:0]          idx_next;
    logic [WW-1:0]          dvd_reg;
    logic [LW-1:0]          rem_reg;
    logic                   last_pend_reg;
    logic                   last_next;
    logic [AW-1:0]          address_reg;
    logic                   is_write_reg;
    logic [mapg_pkg::BYTE_W-1:0] write_byte_reg;
    logic                   last_reg;

    logic [WW-1:0]          seed_src;
    logic [WW-1:0]          seed_mix;
    logic [WW-1:0]          seed_prod;
    logic [WW-1:0]          seed_next;
    logic [WW-1:0]          xs_t;
    logic [WW-1:0]          xs_w;
    logic [WW-1:0]          xs_new;
    logic [WW-1:0]          raw;
    logic [CW-1:0]          count_eff;
    logic [WW-1:0]          idx_plus;
    logic [WW-1:0]          trial;
    logic [WW-1:0]          len_ext;
    logic                   write_flag;
    mapg_pkg::pattern_t     pattern;

    // Seeding recurrence: one multiplication per cycle, one generator word per step.
    always_comb
    begin
        if (cmd.seed_idx == '0)
        begin
            seed_src = cmd.seed_zero ? '0 : seed_value;
        end
        else
        begin
            seed_src = seed_reg;
        end
        seed_mix  = seed_src ^ (seed_src >> mapg_pkg::SEED_SHIFT);
        seed_prod = mapg_pkg::SEED_MULT * seed_mix;
        seed_next = seed_prod + WW'(cmd.seed_idx) + WW'(1);
    end

    always_comb
    begin
        xs_t   = rng_reg[0] ^ (rng_reg[0] << mapg_pkg::XS_SHIFT_A);
        xs_w   = rng_reg[3];
        xs_new = (xs_w ^ (xs_w >> mapg_pkg::XS_SHIFT_B))
               ^ (xs_t ^ (xs_t >> mapg_pkg::XS_SHIFT_C));
    end

    assign pattern = mapg_pkg::pattern_t'(access_mode[mapg_pkg::MODE_W-1:1]);

    always_comb
    begin
        unique case (pattern)
            mapg_pkg::PAT_SEQ:    raw = WW'(idx_reg);
            mapg_pkg::PAT_SPARSE: raw = WW'(idx_reg) + mapg_pkg::SPARSE_OFFSET;
            default:              raw = xs_new;
        endcase
    end

    always_comb
    begin
        count_eff = (access_count == '0) ? CW'(1) : access_count;
        idx_plus  = WW'(idx_reg) + WW'(1);
        last_next = (idx_plus >= WW'(count_eff));
        idx_next  = last_next ? '0 : idx_plus[CW-1:0];
    end

    // One restoring remainder step: shift in the next dividend bit and subtract if it fits.
    always_comb
    begin
        len_ext = WW'(region_length);
        trial   = {rem_reg, dvd_reg[WW-1]};
    end

    assign write_flag = ~access_mode[0];

    always_ff @(posedge clk)
    begin
        if (cmd.seed_step)
        begin
            rng_reg[cmd.seed_idx] <= seed_next;
            seed_reg              <= seed_next;
            if (cmd.seed_idx == '0)
            begin
                idx_reg <= '0;
            end
        end
        if (cmd.gen)
        begin
            if (pattern == mapg_pkg::PAT_RANDOM || pattern == mapg_pkg::PAT_SPARE)
            begin
                rng_reg[0] <= rng_reg[1];
                rng_reg[1] <= rng_reg[2];
                rng_reg[2] <= rng_reg[3];
                rng_reg[3] <= xs_new;
            end
            dvd_reg       <= raw;
            rem_reg       <= '0;
            last_pend_reg <= last_next;
            idx_reg       <= idx_next;
        end
        if (cmd.rem_step)
        begin
            dvd_reg <= dvd_reg << 1;
            if (trial >= len_ext)
            begin
                rem_reg <= LW'(trial - len_ext);
            end
            else
            begin
                rem_reg <= trial[LW-1:0];
            end
        end
        if (cmd.out_load)
        begin
            address_reg    <= (region_length == '0) ? '0 : (rem_reg[AW-1:0] & ADDR_MASK);
            is_write_reg   <= write_flag;
            write_byte_reg <= write_flag ? mapg_pkg::WRITE_BYTE : '0;
            last_reg       <= last_pend_reg;
        end
    end

    assign address    = address_reg;
    assign is_write   = is_write_reg;
    assign write_byte = write_byte_reg;
    assign last       = last_reg;

endmodule

FILE: bench/mapg_checker.sv
`timescale 1ns / 1ps
// Checker for the memory access pattern generator: predicts each access and compares results.
module mapg_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            restart,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [mapg_pkg::ADDR_W-1:0]     address,
    input  logic                            is_write,
    input  logic [mapg_pkg::BYTE_W-1:0]     write_byte,
    input  logic                            last,
    input  logic                            cfg_wr_en,
    input  logic [mapg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mapg_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              outstanding
);

    localparam int unsigned AW = mapg_pkg::ADDR_W;
    localparam int unsigned WW = mapg_pkg::WORD_W;
    localparam int unsigned BW = mapg_pkg::BYTE_W;

    localparam logic [WW-1:0] INIT_MULT     = 32'd1812433253;
    localparam logic [WW-1:0] SPARSE_STRIDE = 32'd65;
    localparam logic [BW-1:0] STORE_BYTE    = 8'h12;
    localparam int            PRINT_LIMIT   = 100;

    typedef struct packed {
        logic [AW-1:0] address;
        logic          is_write;
        logic [BW-1:0] write_byte;
        logic          last;
    } access_t;

    logic [mapg_pkg::MODE_W-1:0] mode_q;
    logic [mapg_pkg::LEN_W-1:0]  length_q;
    logic [mapg_pkg::CNT_W-1:0]  count_q;
    logic [WW-1:0]               seed_q;
    logic [WW-1:0]               words [mapg_pkg::SEED_WORDS];
    logic [mapg_pkg::CNT_W-1:0]  index_q;
    access_t                     expected_accesses [$];

    task reseed_words(input logic [WW-1:0] seed);
        logic [WW-1:0] s;
        int            i;
        s = seed;
        for (i = 0; i < mapg_pkg::SEED_WORDS; i++)
        begin
            s = INIT_MULT * (s ^ (s >> 30)) + WW'(i + 1);
            words[i] = s;
        end
    endtask

    task advance_xorshift(output logic [WW-1:0] word);
        logic [WW-1:0] t;
        logic [WW-1:0] w;
        t = words[0] ^ (words[0] << 11);
        w = words[3];
        words[0] = words[1];
        words[1] = words[2];
        words[2] = w;
        words[3] = (w ^ (w >> 19)) ^ (t ^ (t >> 8));
        word = words[3];
    endtask

    task predict_access(input logic rst, output access_t acc);
        logic [WW-1:0] raw;
        logic [WW-1:0] rem;
        logic [WW-1:0] run_len;
        logic          run_end;
        if (rst)
        begin
            index_q = '0;
            reseed_words(seed_q);
        end
        case (mapg_pkg::pattern_t'(mode_q[mapg_pkg::MODE_W-1:1]))
            mapg_pkg::PAT_SEQ:    raw = {1'b0, index_q};
            mapg_pkg::PAT_SPARSE: raw = {1'b0, index_q} + SPARSE_STRIDE;
            default:              advance_xorshift(raw);
        endcase
        rem = (length_q != '0) ? raw % {1'b0, length_q} : '0;
        acc.address    = rem[AW-1:0];
        acc.is_write   = ~mode_q[0];
        acc.write_byte = acc.is_write ? STORE_BYTE : '0;
        run_len = (count_q != '0) ? {1'b0, count_q} : 32'd1;
        run_end = ({1'b0, index_q} + 32'd1) >= run_len;
        acc.last = run_end;
        index_q  = run_end ? '0 : index_q + 1'b1;
    endtask

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        access_t acc;
        access_t want;
        if (!rst_n)
        begin
            mode_q   = mapg_pkg::MODE_RESET;
            length_q = mapg_pkg::LEN_RESET;
            count_q  = mapg_pkg::COUNT_RESET;
            seed_q   = '0;
            index_q  = '0;
            reseed_words('0);
            expected_accesses.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_accesses.size() == 0)
                    report_mismatch("result with no request waiting", 32'(address), 32'd0);
                else
                begin
                    want = expected_accesses.pop_front();
                    if (address !== want.address)
                        report_mismatch("address", 32'(address), 32'(want.address));
                    if (is_write !== want.is_write)
                        report_mismatch("is_write", 32'(is_write), 32'(want.is_write));
                    if (write_byte !== want.write_byte)
                        report_mismatch("write_byte", 32'(write_byte), 32'(want.write_byte));
                    if (last !== want.last)
                        report_mismatch("last", 32'(last), 32'(want.last));
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    mapg_pkg::REG_MODE:   mode_q   = cfg_data[mapg_pkg::MODE_W-1:0];
                    mapg_pkg::REG_LENGTH: length_q = cfg_data[mapg_pkg::LEN_W-1:0];
                    mapg_pkg::REG_COUNT:  count_q  = cfg_data[mapg_pkg::CNT_W-1:0];
                    mapg_pkg::REG_SEED:   seed_q   = cfg_data[WW-1:0];
                    default:              ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_access(restart, acc);
                expected_accesses.push_back(acc);
            end
            outstanding = expected_accesses.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the memory access pattern generator: stimulus, handshakes and verdict.
module tb_top;

    localparam int RANDOM_REQUESTS = 1900;
    localparam int MAX_IDLE        = 18;

    logic                            clk        = 1'b0;
    logic                            rst_n      = 1'b0;
    logic                            in_valid   = 1'b0;
    logic                            in_ready;
    logic                            restart    = 1'b0;
    logic                            out_valid;
    logic                            out_ready  = 1'b0;
    logic [mapg_pkg::ADDR_W-1:0]     address;
    logic                            is_write;
    logic [mapg_pkg::BYTE_W-1:0]     write_byte;
    logic                            last;
    logic                            cfg_wr_en  = 1'b0;
    logic [mapg_pkg::CFG_IDX_W-1:0]  cfg_index  = mapg_pkg::REG_MODE;
    logic [mapg_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

    int fail_count;
    int outstanding;
    bit steady = 1'b0;
    int requests_sent = 0;
    int restarts_sent = 0;
    int reg_writes = 0;
    int settings = 0;

    memory_access_pattern_generator_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .address    (address),
        .is_write   (is_write),
        .write_byte (write_byte),
        .last       (last),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    mapg_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .address     (address),
        .is_write    (is_write),
        .write_byte  (write_byte),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic int idle_cycles();
        return steady ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    task automatic send_request(input logic rst);
        int gap;
        gap = idle_cycles();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            restart  = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        restart  = rst;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
        if (rst)
            restarts_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input mapg_pkg::cfg_reg_t idx,
                             input logic [mapg_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic end_writes();
        cfg_wr_en = 1'b0;
        settings++;
    endtask

    initial
    begin
        int stall;
        forever
        begin
            stall = idle_cycles();
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        int n;
        int i;
        logic [mapg_pkg::CFG_DATA_W-1:0] value;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        do @(posedge clk); while (!in_ready);

        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        drain();

        write_reg(mapg_pkg::REG_MODE, 32'hFFFF_FFF8);
        write_reg(mapg_pkg::REG_LENGTH, 32'd7);
        write_reg(mapg_pkg::REG_COUNT, 32'd5);
        end_writes();
        send_request(1'b1);
        repeat (5) send_request(1'b0);
        drain();

        write_reg(mapg_pkg::REG_MODE, 32'd1);
        write_reg(mapg_pkg::REG_LENGTH, 32'd0);
        end_writes();
        send_request(1'b0);
        send_request(1'b0);
        drain();

        write_reg(mapg_pkg::REG_MODE, 32'd2);
        write_reg(mapg_pkg::REG_LENGTH, 32'd100);
        write_reg(mapg_pkg::REG_COUNT, 32'd0);
        end_writes();
        send_request(1'b1);
        send_request(1'b0);
        drain();

        write_reg(mapg_pkg::REG_MODE, 32'd3);
        write_reg(mapg_pkg::REG_LENGTH, 32'hFFFF_FFFF);
        write_reg(mapg_pkg::REG_COUNT, 32'hFFFF_FFFF);
        write_reg(mapg_pkg::REG_SEED, 32'hFFFF_FFFF);
        end_writes();
        send_request(1'b0);
        send_request(1'b1);
        drain();

        write_reg(mapg_pkg::REG_MODE, 32'd5);
        write_reg(mapg_pkg::REG_LENGTH, 32'd1);
        end_writes();
        send_request(1'b1);
        send_request(1'b0);
        drain();

        write_reg(mapg_pkg::REG_MODE, 32'd6);
        write_reg(mapg_pkg::REG_LENGTH, 32'd1000);
        end_writes();
        send_request(1'b0);
        drain();
        write_reg(mapg_pkg::REG_MODE, 32'd7);
        end_writes();
        send_request(1'b0);
        drain();

        // Lowering the count mid-run leaves the index beyond the new end of the run.
        write_reg(mapg_pkg::REG_MODE, 32'd0);
        write_reg(mapg_pkg::REG_COUNT, 32'd10);
        write_reg(mapg_pkg::REG_SEED, 32'h1234_5678);
        end_writes();
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        drain();
        write_reg(mapg_pkg::REG_COUNT, 32'd2);
        end_writes();
        send_request(1'b0);
        send_request(1'b0);
        drain();

        while (requests_sent < RANDOM_REQUESTS + 25)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) != 0)
                write_reg(mapg_pkg::REG_MODE, $urandom);
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       value = $urandom_range(1, 16);
                    1:       value = $urandom_range(1, 1000);
                    2:       value = $urandom;
                    3:       value = 32'h4000_0000;
                    4:       value = '0;
                    default: value = $urandom_range(1, 32'h4000_0000);
                endcase
                write_reg(mapg_pkg::REG_LENGTH, value);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 3))
                    0:       value = $urandom_range(1, 8);
                    1:       value = $urandom_range(1, 100);
                    2:       value = $urandom;
                    default: value = '0;
                endcase
                write_reg(mapg_pkg::REG_COUNT, value);
            end
            if ($urandom_range(0, 2) != 0)
                write_reg(mapg_pkg::REG_SEED, $urandom);
            end_writes();
            n = $urandom_range(10, 60);
            for (i = 0; i < n; i++)
            begin
                if (i == 0)
                    send_request(1'($urandom_range(0, 1)));
                else
                    send_request($urandom_range(0, 11) == 0);
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
            drain();
        end

        repeat (45) @(negedge clk);
        $display("Sent %0d requests (%0d with restart) across %0d register settings, %0d writes.",
                 requests_sent, restarts_sent, settings, reg_writes);
        $display("Covered all six modes and both spare codes, zero length and count, wide seeds.");
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
sv/mapg_pkg.sv
sv/mapg_ctrl.sv
sv/mapg_datapath.sv
sv/memory_access_pattern_generator_core.sv
bench/mapg_checker.sv
bench/tb_top.sv
